// ===== rtl/tous_pkg.sv =====
package tous_pkg;

    localparam int KIND_W      = 2;
    localparam int SEL_W       = 2;
    localparam int WDAY_W      = 3;
    localparam int DTYPE_W     = 2;
    localparam int SLOT_W      = 3;
    localparam int HOUR_W      = 5;
    localparam int MIN_W       = 6;
    localparam int SET_W       = 8;
    localparam int DATE_W      = 27;
    localparam int STATUS_W    = 2;
    localparam int CAL_OUT_W   = 2;
    localparam int BAND_OUT_W  = 3;
    localparam int TARIFF_W    = 3;
    localparam int TIME_W      = 12;
    localparam int ENTRY_W     = HOUR_W + MIN_W + SET_W;
    localparam int WEEK_DAYS   = 7;
    localparam int HOUR_SCALE  = 100;

    localparam logic [KIND_W-1:0] KIND_MAP   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BAND  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd3;

    localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NO_CAL  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NO_BAND = 2'd2;
    localparam logic [STATUS_W-1:0] STS_RANGE   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAL,
        S_MAP,
        S_BAND,
        S_FIN
    } t_state;

    typedef struct packed {
        logic capture;
        logic write;
        logic cal_step;
        logic map_step;
        logic band_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic cal_last;
        logic map_err;
        logic band_done;
    } t_stat;

    function automatic logic [TIME_W-1:0] clock_value(input logic [HOUR_W-1:0] hr,
                                                      input logic [MIN_W-1:0] mn);
        clock_value = TIME_W'(hr) * TIME_W'(HOUR_SCALE) + TIME_W'(mn);
    endfunction

endpackage

// ===== rtl/time_of_use_tariff_select.sv =====
// Write words leave busy low, and the result strobe follows in the next cycle.
// A query holds busy while it scans the calendars one per cycle, reads the weekday map,
// then the bands one per cycle, and ends at the map if no calendar, weekday or day type fits.
// A query's result strobe rises in the same cycle that busy falls; results cannot be held off.
// Synchronous active-low reset clears the controller, the present marks, the weekday map
// and the band valid marks, so the weekday map and band table read as zero after reset.
module time_of_use_tariff_select #(
    parameter int CALENDARS = 3,
    parameter int DAY_TYPES = 4,
    parameter int BANDS     = 8,
    parameter int SETTINGS  = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [tous_pkg::KIND_W-1:0]       i_kind,
    input  logic [tous_pkg::SEL_W-1:0]        i_calendar_sel,
    input  logic [tous_pkg::WDAY_W-1:0]       i_week_day,
    input  logic [tous_pkg::DTYPE_W-1:0]      i_day_type,
    input  logic [tous_pkg::SLOT_W-1:0]       i_band_slot,
    input  logic [tous_pkg::HOUR_W-1:0]       i_hour,
    input  logic [tous_pkg::MIN_W-1:0]        i_minute,
    input  logic signed [tous_pkg::SET_W-1:0] i_setting,
    input  logic [tous_pkg::DATE_W-1:0]       i_date,
    input  logic                              i_valid_req,
    output logic                              o_valid,
    output logic [tous_pkg::STATUS_W-1:0]     o_status,
    output logic [tous_pkg::CAL_OUT_W-1:0]    o_calendar_index,
    output logic [tous_pkg::BAND_OUT_W-1:0]   o_band_index,
    output logic [tous_pkg::TARIFF_W-1:0]     o_tariff_index
);

    tous_pkg::t_cmd  cmd;
    tous_pkg::t_stat stat;

    tous_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    tous_dp #(
        .CALENDARS (CALENDARS),
        .DAY_TYPES (DAY_TYPES),
        .BANDS     (BANDS),
        .SETTINGS  (SETTINGS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_kind           (i_kind),
        .i_calendar_sel   (i_calendar_sel),
        .i_week_day       (i_week_day),
        .i_day_type       (i_day_type),
        .i_band_slot      (i_band_slot),
        .i_hour           (i_hour),
        .i_minute         (i_minute),
        .i_setting        (i_setting),
        .i_date           (i_date),
        .i_valid_req      (i_valid_req),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_calendar_index (o_calendar_index),
        .o_band_index     (o_band_index),
        .o_tariff_index   (o_tariff_index)
    );

endmodule

// ===== rtl/tous_ram.sv =====
module tous_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 96
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== rtl/tous_ctrl.sv =====
module tous_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tous_pkg::KIND_W-1:0] i_kind,
    input  tous_pkg::t_stat             i_stat,
    output tous_pkg::t_cmd              o_cmd,
    output logic                        o_busy
);

    tous_pkg::t_state r_state;
    tous_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tous_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tous_pkg::S_IDLE: begin
                if (i_start && i_kind == tous_pkg::KIND_QUERY) begin
                    n_state = tous_pkg::S_CAL;
                end
            end
            tous_pkg::S_CAL: begin
                if (i_stat.cal_last) begin
                    n_state = tous_pkg::S_MAP;
                end
            end
            tous_pkg::S_MAP: begin
                n_state = i_stat.map_err ? tous_pkg::S_IDLE : tous_pkg::S_BAND;
            end
            tous_pkg::S_BAND: begin
                if (i_stat.band_done) begin
                    n_state = tous_pkg::S_FIN;
                end
            end
            tous_pkg::S_FIN: begin
                n_state = tous_pkg::S_IDLE;
            end
            default: begin
                n_state = tous_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            tous_pkg::S_IDLE: begin
                o_busy        = 1'b0;
                o_cmd.capture = i_start;
                o_cmd.write   = i_start && i_kind != tous_pkg::KIND_QUERY;
            end
            tous_pkg::S_CAL: begin
                o_cmd.cal_step = 1'b1;
            end
            tous_pkg::S_MAP: begin
                o_cmd.map_step = 1'b1;
            end
            tous_pkg::S_BAND: begin
                o_cmd.band_step = 1'b1;
            end
            tous_pkg::S_FIN: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/tous_dp.sv =====
module tous_dp #(
    parameter int CALENDARS = 3,
    parameter int DAY_TYPES = 4,
    parameter int BANDS     = 8,
    parameter int SETTINGS  = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tous_pkg::t_cmd                   i_cmd,
    output tous_pkg::t_stat                  o_stat,
    input  logic [tous_pkg::KIND_W-1:0]      i_kind,
    input  logic [tous_pkg::SEL_W-1:0]       i_calendar_sel,
    input  logic [tous_pkg::WDAY_W-1:0]      i_week_day,
    input  logic [tous_pkg::DTYPE_W-1:0]     i_day_type,
    input  logic [tous_pkg::SLOT_W-1:0]      i_band_slot,
    input  logic [tous_pkg::HOUR_W-1:0]      i_hour,
    input  logic [tous_pkg::MIN_W-1:0]       i_minute,
    input  logic signed [tous_pkg::SET_W-1:0] i_setting,
    input  logic [tous_pkg::DATE_W-1:0]      i_date,
    input  logic                             i_valid_req,
    output logic                             o_valid,
    output logic [tous_pkg::STATUS_W-1:0]    o_status,
    output logic [tous_pkg::CAL_OUT_W-1:0]   o_calendar_index,
    output logic [tous_pkg::BAND_OUT_W-1:0]  o_band_index,
    output logic [tous_pkg::TARIFF_W-1:0]    o_tariff_index
);

    localparam int CW     = CALENDARS > 1 ? $clog2(CALENDARS) : 1;
    localparam int BW     = BANDS > 1 ? $clog2(BANDS) : 1;
    localparam int MDEPTH = CALENDARS * tous_pkg::WEEK_DAYS;
    localparam int MW     = MDEPTH > 1 ? $clog2(MDEPTH) : 1;
    localparam int RDEPTH = CALENDARS * DAY_TYPES * BANDS;
    localparam int AW     = RDEPTH > 1 ? $clog2(RDEPTH) : 1;
    localparam int TW     = tous_pkg::TIME_W;
    localparam int EW     = tous_pkg::ENTRY_W;
    localparam int SW     = tous_pkg::SET_W;

    logic [CALENDARS-1:0]              r_present;
    logic [tous_pkg::DATE_W-1:0]       r_date [CALENDARS];
    logic [tous_pkg::DTYPE_W-1:0]      r_map [MDEPTH];
    logic [RDEPTH-1:0]                 r_bvalid;

    logic [tous_pkg::WDAY_W-1:0]       r_wd;
    logic [TW-1:0]                     r_now;
    logic [tous_pkg::DATE_W-1:0]       r_today;
    logic [CW-1:0]                     r_cal_cnt;
    logic                              r_found;
    logic [CW-1:0]                     r_best;
    logic [tous_pkg::DATE_W-1:0]       r_best_date;
    logic [AW-1:0]                     r_base;
    logic [BW-1:0]                     r_band_idx;
    logic                              r_have;
    logic [BW-1:0]                     r_target;
    logic [SW-1:0]                     r_set;
    logic                              r_rd_valid;

    logic                              cal_ok;
    logic                              map_ok;
    logic                              band_ok;
    logic                              cal_hit;
    logic [MW-1:0]                     map_idx;
    logic [tous_pkg::DTYPE_W-1:0]      mapped;
    logic                              wd_bad;
    logic [AW-1:0]                     waddr;
    logic                              we;
    logic                              re;
    logic [AW-1:0]                     raddr;
    logic [EW-1:0]                     rdata;
    logic [EW-1:0]                     entry;
    logic [TW-1:0]                     start_time;
    logic                              band_stop;
    logic                              band_last;
    logic                              emit;
    logic [tous_pkg::STATUS_W-1:0]     emit_status;
    logic                              set_ok;

    assign cal_ok  = 32'(i_calendar_sel) < CALENDARS;
    assign map_ok  = cal_ok && 32'(i_week_day) < tous_pkg::WEEK_DAYS;
    assign band_ok = cal_ok && 32'(i_day_type) < DAY_TYPES && 32'(i_band_slot) < BANDS;
    assign waddr   = AW'((int'(i_calendar_sel) * DAY_TYPES + int'(i_day_type)) * BANDS
                         + int'(i_band_slot));
    assign we      = i_cmd.write && i_kind == tous_pkg::KIND_BAND && band_ok;

    assign cal_hit = r_present[r_cal_cnt] && r_date[r_cal_cnt] <= r_today &&
                     (!r_found || r_date[r_cal_cnt] > r_best_date);

    assign wd_bad  = 32'(r_wd) >= tous_pkg::WEEK_DAYS;
    assign map_idx = wd_bad ? '0 : MW'(int'(r_best) * tous_pkg::WEEK_DAYS + int'(r_wd));
    assign mapped  = r_map[map_idx];

    assign entry      = r_rd_valid ? rdata : '0;
    assign start_time = tous_pkg::clock_value(entry[EW-1 -: tous_pkg::HOUR_W],
                                              entry[SW +: tous_pkg::MIN_W]);
    assign band_stop  = (start_time == '0 && r_band_idx != '0) || r_now < start_time;
    assign band_last  = r_band_idx == BW'(BANDS - 1);

    assign o_stat.cal_last  = r_cal_cnt == CW'(CALENDARS - 1);
    assign o_stat.map_err   = !r_found || wd_bad || 32'(mapped) >= DAY_TYPES;
    assign o_stat.band_done = band_stop || band_last;

    always_comb begin
        re    = 1'b0;
        raddr = r_base + AW'(r_band_idx) + AW'(1);
        if (i_cmd.map_step) begin
            re    = 1'b1;
            raddr = AW'((int'(r_best) * DAY_TYPES + int'(mapped)) * BANDS);
        end else if (i_cmd.band_step && !band_stop && !band_last) begin
            re = 1'b1;
        end
    end

    tous_ram #(
        .WIDTH (EW),
        .DEPTH (RDEPTH)
    ) u_band_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata ({i_hour, i_minute, i_setting}),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Table state: present marks, weekday map and band valid marks clear on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_bvalid  <= '0;
            for (int i = 0; i < MDEPTH; i++) begin
                r_map[i] <= '0;
            end
        end else if (i_cmd.write) begin
            if (i_kind == tous_pkg::KIND_MAP && map_ok) begin
                r_map[MW'(int'(i_calendar_sel) * tous_pkg::WEEK_DAYS + int'(i_week_day))]
                    <= i_day_type;
            end
            if (we) begin
                r_bvalid[waddr] <= 1'b1;
            end
            if (i_kind == tous_pkg::KIND_DATE && cal_ok) begin
                r_present[CW'(i_calendar_sel)] <= i_valid_req;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && i_kind == tous_pkg::KIND_DATE && cal_ok) begin
            r_date[CW'(i_calendar_sel)] <= i_date;
        end
        if (re) begin
            r_rd_valid <= r_bvalid[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_wd    <= i_week_day;
            r_now   <= tous_pkg::clock_value(i_hour, i_minute);
            r_today <= i_date;
        end
        if (i_cmd.capture) begin
            r_cal_cnt <= '0;
            r_found   <= 1'b0;
            r_best    <= '0;
        end else if (i_cmd.cal_step) begin
            r_cal_cnt <= r_cal_cnt + CW'(1);
            if (cal_hit) begin
                r_found     <= 1'b1;
                r_best      <= r_cal_cnt;
                r_best_date <= r_date[r_cal_cnt];
            end
        end
        if (i_cmd.map_step) begin
            r_base     <= raddr;
            r_band_idx <= '0;
            r_have     <= 1'b0;
        end else if (i_cmd.band_step) begin
            r_band_idx <= r_band_idx + BW'(1);
            if (!band_stop) begin
                r_have   <= 1'b1;
                r_target <= r_band_idx;
                r_set    <= entry[SW-1:0];
            end
        end
    end

    assign set_ok = !r_set[SW-1] && 32'(r_set) < SETTINGS;

    always_comb begin
        emit        = 1'b0;
        emit_status = tous_pkg::STS_OK;
        if (i_cmd.write) begin
            emit = 1'b1;
        end else if (i_cmd.map_step && o_stat.map_err) begin
            emit        = 1'b1;
            emit_status = r_found ? tous_pkg::STS_NO_BAND : tous_pkg::STS_NO_CAL;
        end else if (i_cmd.finish) begin
            emit = 1'b1;
            if (!r_have) begin
                emit_status = tous_pkg::STS_NO_BAND;
            end else if (!set_ok) begin
                emit_status = tous_pkg::STS_RANGE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_status         <= emit_status;
            o_calendar_index <= '0;
            o_band_index     <= '0;
            o_tariff_index   <= '0;
            if (i_cmd.finish && emit_status == tous_pkg::STS_OK) begin
                o_calendar_index <= tous_pkg::CAL_OUT_W'(r_best);
                o_band_index     <= tous_pkg::BAND_OUT_W'(r_target);
                o_tariff_index   <= r_set[tous_pkg::TARIFF_W-1:0];
            end
        end
    end

endmodule
